// ----- rtl/rsme_pkg.sv -----
// ----------------------------------------------------------------------------
// rsme_pkg
// shared widths, codes and types for the symbol modular exponentiation block
// ----------------------------------------------------------------------------
package rsme_pkg;

    localparam int SYM_W      = 16;
    localparam int EXP_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [SYM_W-1:0] PRINT_LOW  = SYM_W'(32);
    localparam logic [SYM_W-1:0] PRINT_HIGH = SYM_W'(126);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS  = 2'd0,
        CFG_EXPONENT = 2'd1,
        CFG_DECRYPT  = 2'd2
    } t_cfg_idx;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

// ----- rtl/rsme_mulmod.sv -----
// ----------------------------------------------------------------------------
// rsme_mulmod
// bit-serial interleaved modular multiplier: p = a * b mod m, one bit of b
// per cycle from the msb down, a < m and m >= 2 required
// ----------------------------------------------------------------------------
module rsme_mulmod import rsme_pkg::*; #(
    parameter int W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W-1:0]     i_a,
    input  logic [SYM_W-1:0] i_b,
    input  logic [W-1:0]     i_m,
    output t_mm_stat         o_stat,
    output logic [W-1:0]     o_p
);

    localparam int CNT_W = $clog2(SYM_W);

    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_a;
    logic [SYM_W-1:0] r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W:0]   dbl;
    logic [W-1:0] red1;
    logic [W:0]   sum;
    logic [W-1:0] red2;
    logic [W-1:0] n_acc;

    // double then conditionally add, each folded back below m by one subtract
    always_comb begin
        dbl  = {r_acc, 1'b0};
        red1 = (dbl >= {1'b0, i_m}) ? W'(dbl - {1'b0, i_m}) : dbl[W-1:0];
        sum  = {1'b0, red1} + {1'b0, r_a};
        red2 = (sum >= {1'b0, i_m}) ? W'(sum - {1'b0, i_m}) : sum[W-1:0];
        n_acc = r_b[SYM_W-1] ? red2 : red1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= {r_b[SYM_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SYM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_p         = r_acc;

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a running multiply");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_a < i_m) |-> (r_acc < i_m))
        else $error("partial product not reduced");
`endif

endmodule

// ----- rtl/rsa_symbol_modexp_unit.sv -----
// beats are handled one at a time; the result waits in S_DONE until the output register is free,
// and the next input beat can be taken in the cycle after the result loads
// each product on the shared multiplier runs start, 16 bit steps, then done:
// one to reduce the symbol, one square per exponent bit, one multiply per set bit
// reset: synchronous active low; modulus 2, exponent 1, encrypt mode, idle
// ----------------------------------------------------------------------------
// rsa_symbol_modexp_unit
// symbol ^ exponent mod modulus by msb-first square-and-multiply, with a
// printable-range keep flag in decrypt mode
// ----------------------------------------------------------------------------
module rsa_symbol_modexp_unit import rsme_pkg::*; #(
    parameter int MODULUS_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SYM_W-1:0]      s_axis_tdata,   // [15:0] symbol_in
    input  logic                  s_axis_tlast,   // last_in
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SYM_W-1:0]      m_axis_tdata,   // [15:0] symbol_out
    output logic                  m_axis_tuser,   // [0] keep
    output logic                  m_axis_tlast    // last_out
);

    localparam int MW    = (MODULUS_BITS < SYM_W) ? MODULUS_BITS : SYM_W;
    localparam int BIT_W = $clog2(EXP_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_SQR,
        S_MUL,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [MW-1:0]    r_modulus;
    logic [EXP_W-1:0] r_exponent;
    logic             r_dec;
    logic [SYM_W-1:0] r_sym;
    logic             r_last;
    logic [MW-1:0]    r_base;
    logic [MW-1:0]    r_acc;
    logic [BIT_W-1:0] r_bit;
    logic             r_start;
    logic             r_o_valid;
    logic [SYM_W-1:0] r_o_sym;
    logic             r_o_keep;
    logic             r_o_last;

    t_mm_stat         mm_stat;
    logic [MW-1:0]    mm_p;
    logic [MW-1:0]    mm_a;
    logic [SYM_W-1:0] mm_b;
    logic             in_acc;
    logic             out_free;
    logic [SYM_W-1:0] res_ext;
    logic             res_keep;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_o_valid || m_axis_tready;
    assign res_ext  = SYM_W'(r_acc);
    assign res_keep = !r_dec || (res_ext >= PRINT_LOW && res_ext <= PRINT_HIGH);

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_RED: begin
                mm_a = MW'(1);
                mm_b = r_sym;
            end
            S_MUL: begin
                mm_a = r_base;
                mm_b = SYM_W'(r_acc);
            end
            default: begin
                mm_a = r_acc;
                mm_b = SYM_W'(r_acc);
            end
        endcase
    end

    rsme_mulmod #(
        .W (MW)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (r_modulus),
        .o_stat  (mm_stat),
        .o_p     (mm_p)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MW'(2);
            r_exponent <= EXP_W'(1);
            r_dec      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODULUS:  r_modulus  <= i_cfg_data[MW-1:0];
                CFG_EXPONENT: r_exponent <= i_cfg_data[EXP_W-1:0];
                CFG_DECRYPT:  r_dec      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_o_valid <= 1'b0;
            r_bit     <= '0;
        end else begin
            r_start <= 1'b0;
            // in S_DONE the output register is reloaded instead
            if (r_o_valid && m_axis_tready && r_state != S_DONE) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sym  <= s_axis_tdata;
                        r_last <= s_axis_tlast;
                        if (r_modulus <= MW'(1)) begin
                            r_acc   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RED;
                            r_start <= 1'b1;
                        end
                    end
                end
                S_RED: begin
                    if (mm_stat.done) begin
                        r_base  <= mm_p;
                        r_acc   <= MW'(1);
                        r_bit   <= BIT_W'(EXP_W - 1);
                        r_state <= S_SQR;
                        r_start <= 1'b1;
                    end
                end
                S_SQR: begin
                    if (mm_stat.done) begin
                        r_acc <= mm_p;
                        if (r_exponent[r_bit]) begin
                            r_state <= S_MUL;
                            r_start <= 1'b1;
                        end else if (r_bit == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_bit   <= r_bit - 1'b1;
                            r_start <= 1'b1;
                        end
                    end
                end
                S_MUL: begin
                    if (mm_stat.done) begin
                        r_acc <= mm_p;
                        if (r_bit == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_bit   <= r_bit - 1'b1;
                            r_state <= S_SQR;
                            r_start <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_sym   <= res_ext;
                        r_o_keep  <= res_keep;
                        r_o_last  <= r_last;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_sym;
    assign m_axis_tuser  = r_o_keep;
    assign m_axis_tlast  = r_o_last;

`ifndef ASSERT_OFF
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_stat.done |-> (r_state == S_RED || r_state == S_SQR || r_state == S_MUL))
        else $error("multiplier result with no product pending");

    a_start_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state == S_RED || r_state == S_SQR || r_state == S_MUL))
        else $error("multiply started outside the exponent loop");

    a_encrypt_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_dec) |-> m_axis_tuser)
        else $error("result dropped in encrypt mode");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_modulus > MW'(1)) |-> (m_axis_tdata < SYM_W'(r_modulus)))
        else $error("result not below modulus");
`endif

endmodule

// ----- dv/tb_rsa_symbol_modexp_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rsa_symbol_modexp_unit
// streams symbols through the modexp unit under several modulus, exponent
// and mode settings, predicts each result in the bench and checks every
// output beat against it while both stream sides stall at random in all
// but one phase, which runs with no idle cycles
module tb_rsa_symbol_modexp_unit;
    import rsme_pkg::*;

    localparam int IDLE_PCT       = 35;
    localparam int SETTLE_CYCLES  = 600;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RAND_PHASES    = 8;
    // index past the last register, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_symbol_beat;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             keep;
        logic             last;
    } t_modexp_result;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SYM_W-1:0]      s_axis_tdata  = '0;   // [15:0] symbol_in
    logic                  s_axis_tlast  = 1'b0; // last_in
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [SYM_W-1:0]      m_axis_tdata;         // [15:0] symbol_out
    logic                  m_axis_tuser;         // [0] keep
    logic                  m_axis_tlast;         // last_out

    // bench copy of the register file
    logic [SYM_W-1:0] cfg_modulus  = SYM_W'(2);
    logic [EXP_W-1:0] cfg_exponent = EXP_W'(1);
    logic             cfg_decrypt  = 1'b0;

    t_symbol_beat   symbol_feed[$];
    t_modexp_result modexp_expected[$];
    t_symbol_beat   next_beat;
    t_symbol_beat   taken_beat;
    t_modexp_result want;
    int             beats_in_flight = 0;
    int             quiet_cycles    = 0;
    int             n_errors        = 0;
    logic           in_taken        = 1'b0;
    logic           no_idle         = 1'b0;

    rsa_symbol_modexp_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // msb-first square-and-multiply, products kept at double width
    function automatic logic [SYM_W-1:0] raise_mod(input logic [SYM_W-1:0] base_in,
                                                   input logic [EXP_W-1:0] power,
                                                   input logic [SYM_W-1:0] modv);
        logic [SYM_W-1:0]   base_r;
        logic [SYM_W-1:0]   acc;
        logic [2*SYM_W-1:0] prod;
        if (modv < SYM_W'(2)) begin
            return '0;
        end
        base_r = base_in % modv;
        acc    = SYM_W'(1);
        for (int b = EXP_W - 1; b >= 0; b--) begin
            prod = acc * acc;
            acc  = SYM_W'(prod % modv);
            if (power[b]) begin
                prod = acc * base_r;
                acc  = SYM_W'(prod % modv);
            end
        end
        return acc;
    endfunction

    function automatic t_modexp_result predict_modexp(input t_symbol_beat beat);
        t_modexp_result r;
        r.symbol = raise_mod(beat.symbol, cfg_exponent, cfg_modulus);
        r.keep   = cfg_decrypt ? (r.symbol >= PRINT_LOW && r.symbol <= PRINT_HIGH) : 1'b1;
        r.last   = beat.last;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MODULUS:  cfg_modulus  = data;
            CFG_EXPONENT: cfg_exponent = data;
            CFG_DECRYPT:  cfg_decrypt  = data[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] modv, input logic [CFG_DATA_W-1:0] power,
                              input logic [CFG_DATA_W-1:0] mode);
        write_reg(CFG_MODULUS, modv);
        write_reg(CFG_EXPONENT, power);
        write_reg(CFG_DECRYPT, mode);
    endtask

    task automatic push_symbol(input logic [SYM_W-1:0] sym, input logic last);
        symbol_feed.push_back('{symbol: sym, last: last});
        beats_in_flight++;
    endtask

    // sender holds off until the unit has returned everything, then settles
    task automatic drain_and_settle();
        while (beats_in_flight != 0 || modexp_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // driver: input beats and output backpressure change on the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (symbol_feed.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                next_beat = symbol_feed.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_beat.symbol;
                s_axis_tlast  <= next_beat.last;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predicts on input beats, checks output beats
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                taken_beat.symbol = s_axis_tdata;
                taken_beat.last   = s_axis_tlast;
                modexp_expected.push_back(predict_modexp(taken_beat));
                beats_in_flight--;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (modexp_expected.size() == 0) begin
                    $error("unexpected output beat, symbol_out %0d", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = modexp_expected.pop_front();
                    if (m_axis_tdata !== want.symbol) begin
                        $error("symbol_out: expected %0d, got %0d", want.symbol, m_axis_tdata);
                        n_errors++;
                    end
                    if (m_axis_tuser !== want.keep) begin
                        $error("keep: expected %0d, got %0d", want.keep, m_axis_tuser);
                        n_errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_out: expected %0d, got %0d", want.last, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("FAIL");
        $finish;
    end

    initial begin
        int               n_items;
        int               kind;
        logic [SYM_W-1:0] n_key;
        logic [EXP_W-1:0] e_key;
        logic [EXP_W-1:0] d_key;
        logic [SYM_W-1:0] rnd_mod;
        logic [7:0]       plain;
        logic             last;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: modulus 2, exponent 1, encrypt
        push_symbol(16'hFFFF, 1'b0);
        push_symbol(16'h0002, 1'b1);
        drain_and_settle();

        // small textbook key, plus a dropped write to the spare index
        set_config(16'd3233, 16'd17, 16'd0);
        write_reg(CFG_SPARE, 16'h0001);
        push_symbol(16'd0, 1'b0);
        push_symbol(16'd65, 1'b0);
        push_symbol(16'hFFFF, 1'b0);
        push_symbol(16'd3232, 1'b1);
        drain_and_settle();

        // zero exponent gives 1 even for symbol 0
        write_reg(CFG_EXPONENT, 16'd0);
        push_symbol(16'd0, 1'b0);
        push_symbol(16'd5, 1'b0);
        push_symbol(16'hFFFF, 1'b1);
        drain_and_settle();

        set_config(16'hFFFF, 16'hFFFF, 16'd0);
        push_symbol(16'hFFFF, 1'b0);
        push_symbol(16'hFFFE, 1'b0);
        push_symbol(16'd2, 1'b1);
        drain_and_settle();

        // degenerate moduli force a zero result
        set_config(16'd0, 16'h1234, 16'd1);
        push_symbol(16'd7, 1'b0);
        push_symbol(16'd0, 1'b1);
        drain_and_settle();
        set_config(16'd1, 16'd0, 16'd0);
        push_symbol(16'hFFFF, 1'b0);
        push_symbol(16'd0, 1'b1);
        drain_and_settle();

        // identity exponent in decrypt mode walks the printable bounds
        set_config(16'hFFFF, 16'd1, 16'd1);
        push_symbol(16'd31, 1'b0);
        push_symbol(16'd32, 1'b0);
        push_symbol(16'd126, 1'b0);
        push_symbol(16'd127, 1'b1);
        drain_and_settle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            no_idle = (ph == 3);
            kind    = ph % 3;
            if ($urandom_range(1) != 0) begin
                n_key = 16'd64507;
                e_key = 16'd3;
                d_key = 16'd42667;
            end else begin
                n_key = 16'd3233;
                e_key = 16'd17;
                d_key = 16'd2753;
            end
            case ($urandom_range(9))
                0:       rnd_mod = SYM_W'($urandom_range(1));
                1, 2:    rnd_mod = SYM_W'($urandom_range(40, 2));
                default: rnd_mod = SYM_W'($urandom);
            endcase
            case (kind)
                0: set_config(rnd_mod, EXP_W'($urandom), CFG_DATA_W'($urandom));
                1: set_config(n_key, e_key, {CFG_DATA_W'($urandom) & 16'hFFFE});
                default: set_config(n_key, d_key, {CFG_DATA_W'($urandom) | 16'h0001});
            endcase
            n_items = $urandom_range(55, 40);
            for (int i = 0; i < n_items; i++) begin
                last = ($urandom_range(9) == 0) || (i == n_items - 1);
                if ($urandom_range(4) != 0) begin
                    plain = 8'($urandom_range(126, 32));
                end else begin
                    plain = 8'($urandom_range(255));
                end
                case (kind)
                    0: push_symbol(SYM_W'($urandom), last);
                    1: push_symbol({8'd0, plain}, last);
                    // ciphertext of a message byte, so decryption recovers the byte, mostly printable text
                    default: push_symbol(raise_mod({8'd0, plain}, e_key, n_key), last);
                endcase
            end
            drain_and_settle();
        end
        no_idle = 1'b0;

        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rsme_pkg.sv
rtl/rsme_mulmod.sv
rtl/rsa_symbol_modexp_unit.sv
dv/tb_rsa_symbol_modexp_unit.sv
